// ----- rtl/asc_pkg.sv -----
`timescale 1ns / 1ps
package asc_pkg;

   localparam int TABLE_ENTRIES = 1000;
   localparam int ROM_SIZE = 1000;
   localparam int ROM_HEAD = 20;
   localparam int IDX_W = $clog2(ROM_SIZE);
   localparam int IDX_MAX = (TABLE_ENTRIES - 1 < ROM_SIZE - 1) ? TABLE_ENTRIES - 1
                                                                : ROM_SIZE - 1;
   localparam int TE_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_PROD_W = 17 + TE_W + 1;
   localparam int ALPHA_W = 16;
   localparam int SQRT_W = 25;
   localparam int D_W = 57;
   localparam int Q_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int CH = 3;

   typedef logic [31:0] head_table_type [ROM_HEAD];
   typedef logic [31:0] tail_table_type [ROM_SIZE - ROM_HEAD];
   typedef logic [ALPHA_W-1:0] alpha_table_type [ROM_SIZE];
   typedef logic [SQRT_W-1:0] sqrt_table_type [ROM_SIZE];

   localparam head_table_type ALPHA_HEAD = '{
      0,560786,1119630,1670650,2218160,2759560,3296210,3828120,4354400,4876950,
      5393340,5906670,6413630,6917860,7415840,7911100,8400550,8886970,9368320,9846020
   };

   localparam tail_table_type ALPHA_TAIL = '{
103197,107888,112552,117159,121755,126277,130800,135249,139689,144079,
148438,152773,157052,161330,165535,169734,173892,178013,182129,186173,
190217,194218,198186,202152,206045,209938,213799,217619,221438,225200,
228947,232686,236361,240036,243686,247289,250893,254459,257992,261526,
265012,268477,271942,275354,278750,282147,285490,288819,292149,295427,
298690,301953,305172,308370,311568,314732,317865,320998,324113,327182,
330251,333320,336327,339333,342340,345307,348251,351195,354127,357010,
359893,362776,365616,368439,371261,374077,376839,379602,382365,385100,
387804,390508,393212,395873,398519,401165,403811,406404,408992,411581,
414168,416700,419232,421763,424294,426769,429245,431721,434196,436620,
439041,441461,443881,446260,448626,450992,453357,455696,458008,460320,
462632,464937,467196,469455,471714,473972,476196,478403,480609,482815,
485017,487171,489326,491480,493634,495768,497871,499974,502077,504180,
506253,508306,510358,512410,514462,516481,518484,520486,522488,524490,
526462,528414,530367,532320,534273,536203,538107,540011,541915,543819,
545716,547571,549427,551282,553138,554993,556815,558623,560431,562238,
564046,565849,567609,569369,571130,572890,574651,576394,578108,579821,
581535,583249,584962,586654,588322,589989,591657,593324,594992,596640,
598262,599884,601505,603127,604749,606362,607939,609515,611092,612668,
614245,615821,617363,618895,620426,621958,623490,625022,626545,628032,
629520,631007,632495,633982,635470,636940,638383,639827,641270,642714,
644158,645601,647027,648427,649827,651227,652628,654028,655428,656820,
658177,659534,660891,662248,663605,664962,666319,667644,668959,670273,
671587,672902,674216,675530,676842,678114,679386,680658,681930,683202,
684474,685746,687013,688243,689473,690703,691933,693163,694393,695623,
696853,698045,699234,700422,701610,702799,703987,705176,706364,707535,
708682,709829,710976,712123,713270,714417,715564,716711,717834,718939,
720045,721151,722257,723363,724469,725575,726681,727767,728832,729898,
730963,732028,733093,734158,735223,736288,737353,738378,739402,740427,
741451,742476,743500,744524,745549,746573,747593,748577,749561,750545,
751529,752513,753497,754481,755465,756449,757433,758382,759326,760270,
761213,762157,763101,764045,764988,765932,766876,767813,768717,769621,
770524,771428,772332,773235,774139,775042,775946,776850,777753,778618,
779482,780345,781209,782072,782936,783800,784663,785527,786390,787254,
788106,788930,789754,790577,791401,792225,793048,793872,794696,795519,
796343,797167,797990,798774,799557,800341,801125,801909,802692,803476,
804260,805044,805827,806611,807395,808174,808918,809661,810405,811149,
811893,812637,813381,814124,814868,815612,816356,817100,817844,818566,
819270,819973,820677,821381,822085,822789,823493,824197,824901,825604,
826308,827012,827716,828412,829076,829740,830404,831068,831731,832395,
833059,833723,834387,835051,835714,836378,837042,837706,838370,838994,
839618,840242,840865,841489,842113,842737,843360,843984,844608,845231,
845855,846479,847102,847726,848350,848942,849525,850109,850692,851275,
851859,852442,853025,853609,854192,854775,855359,855942,856526,857109,
857692,858276,858840,859383,859926,860469,861011,861554,862097,862640,
863183,863726,864268,864811,865354,865897,866440,866983,867525,868068,
868611,869119,869621,870123,870625,871127,871629,872131,872634,873136,
873638,874140,874642,875144,875646,876148,876650,877152,877654,878157,
878659,879130,879591,880052,880514,880975,881436,881897,882358,882819,
883280,883741,884202,884663,885124,885585,886047,886508,886969,887430,
887891,888352,888813,889240,889659,890079,890499,890919,891339,891759,
892178,892598,893018,893438,893858,894277,894697,895117,895537,895957,
896377,896796,897216,897636,898056,898476,898895,899283,899661,900040,
900418,900796,901175,901553,901931,902309,902688,903066,903444,903823,
904201,904579,904957,905336,905714,906092,906471,906849,907227,907606,
907984,908362,908740,909116,909452,909789,910125,910462,910798,911135,
911471,911808,912145,912481,912818,913154,913491,913827,914164,914500,
914837,915174,915510,915847,916183,916520,916856,917193,917529,917866,
918203,918539,918876,919210,919504,919799,920094,920388,920683,920978,
921272,921567,921862,922156,922451,922746,923040,923335,923630,923924,
924219,924514,924808,925103,925398,925692,925987,926282,926576,926871,
927166,927461,927755,928050,928345,928639,928934,929229,929490,929743,
929996,930249,930502,930754,931007,931260,931513,931766,932018,932271,
932524,932777,933029,933282,933535,933788,934041,934293,934546,934799,
935052,935305,935557,935810,936063,936316,936568,936821,937074,937327,
937580,937832,938085,938338,938591,938844,939096,939349,939568,939779,
939990,940201,940412,940623,940834,941045,941256,941467,941678,941890,
942101,942312,942523,942734,942945,943156,943367,943578,943789,944000,
944212,944423,944634,944845,945056,945267,945478,945689,945900,946111,
946322,946534,946745,946956,947167,947378,947589,947800,948011,948222,
948433,948645,948856,949067,949278,949489,949660,949830,950000,950170,
950340,950509,950679,950849,951019,951189,951359,951529,951699,951869,
952038,952208,952378,952548,952718,952888,953058,953228,953398,953567,
953737,953907,954077,954247,954417,954587,954757,954927,955096,955266,
955436,955606,955776,955946,956116,956286,956456,956625,956795,956965,
957135,957305,957475,957645,957815,957985,958154,958324,958494,958664,
958834,959004,959174,959344,959514,959663,959792,959922,960051,960181,
960311,960440,960570,960699,960829,960959,961088,961218,961347,961477,
961606,961736,961866,961995,962125,962254,962384,962514,962643,962773,
962902,963032,963162,963291,963421,963550,963680,963809,963939,964069,
964198,964328,964457,964587,964717,964846,964976,965105,965235,965364,
965494,965624,965753,965883,966012,966142,966272,966401,966531,966660,
966790,966919,967049,967179,967308,967438,967567,967697,967827,967956,
968086,968215,968345,968474,968604,968734,968863,968993,969122,969252,
969382,969511,969641,969748,969839,969930,970020,970111,970202,970292,
970383,970474,970564,970655,970746,970836,970927,971018,971108,971199,
971290,971380,971471,971562,971652,971743,971834,971924,972015,972106,
972197,972287,972378,972469,972559,972650,972741,972831,972922,973013,
973103,973194,973285,973375,973466,973557,973647,973738,973829,973919,
974010,974101,974191,974282,974373,974463,974554,974645,974735,974826,
974917,975007,975098,975189,975279,975370,975461,975551,975642,975733,
975823,975914,976005,976095,976186,976277,976368,976458,976549,976640,
976730,976821,976912,977002,977093,977184,977274,977365,977456,977546,
977637,977728,977818,977909,978000,978090,978181,978272,978362,978453,
978544,978634,978725,978816,978906,978997,979088,979178,979269,979360,
979450,979541,979632,979722,979807,979861,979914,979968,980021,980075,
980128,980182,980236,980289,980343,980396,980450,980503,980557,980611,
980664,980718,980771,980825,980878,980932,980986,981039,981093,981146
   };

   function automatic alpha_table_type make_alpha_rom();
      alpha_table_type rom;
      longint unsigned v;
      for (int i = 0; i < ROM_SIZE; i++) begin
         if (i < ROM_HEAD) begin
            v = (longint'(ALPHA_HEAD[i]) * 65536 + 50000000) / 100000000;
         end else begin
            v = (longint'(ALPHA_TAIL[i - ROM_HEAD]) * 65536 + 500000) / 1000000;
         end
         rom[i] = v[ALPHA_W-1:0];
      end
      return rom;
   endfunction

   localparam alpha_table_type ALPHA_ROM = make_alpha_rom();

   function automatic longint unsigned isqrt(longint unsigned val);
      longint unsigned v;
      longint unsigned r;
      longint unsigned b;
      v = val;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic sqrt_table_type make_sqrt_rom();
      sqrt_table_type rom;
      longint unsigned t;
      longint unsigned s;
      for (int i = 0; i < ROM_SIZE; i++) begin
         t = 3 * (65536 - longint'(ALPHA_ROM[i]));
         s = isqrt(t << 32);
         rom[i] = s[SQRT_W-1:0];
      end
      return rom;
   endfunction

   // sqrt(3*(1-alpha)) in Q.24, one entry per alpha entry
   localparam sqrt_table_type SQRT_ROM = make_sqrt_rom();

   typedef struct packed {
      logic [D_W-1:0]     d;
      logic [ALPHA_W-1:0] alpha;
   } chan_type;

   typedef chan_type [CH-1:0] entry_type;

   typedef struct packed {
      logic [D_W-1:0]     d;
      logic [D_W-1:0]     rem;
      logic [Q_W-1:0]     nlow;
      logic [Q_W-1:0]     q;
      logic [ALPHA_W-1:0] alpha;
      logic               sat;
   } div_type;

   typedef struct packed {
      logic push;
      logic full;
      logic pop;
      logic empty;
   } queue_ctl_type;

endpackage

// ----- rtl/asc_req_if.sv -----
`timescale 1ns / 1ps
interface asc_req_if;
   logic        valid;
   logic        ready;
   logic [16:0] refl_red;
   logic [16:0] refl_green;
   logic [16:0] refl_blue;
   logic [31:0] path_red;
   logic [31:0] path_green;
   logic [31:0] path_blue;

   modport source (output valid, refl_red, refl_green, refl_blue,
                   path_red, path_green, path_blue, input ready);
   modport sink (input valid, refl_red, refl_green, refl_blue,
                 path_red, path_green, path_blue, output ready);
endinterface

// ----- rtl/asc_rsp_if.sv -----
`timescale 1ns / 1ps
interface asc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] scatter_red;
   logic [31:0] scatter_green;
   logic [31:0] scatter_blue;
   logic [31:0] absorb_red;
   logic [31:0] absorb_green;
   logic [31:0] absorb_blue;
   logic [2:0]  saturated_mask;

   modport source (output valid, scatter_red, scatter_green, scatter_blue,
                   absorb_red, absorb_green, absorb_blue, saturated_mask, input ready);
   modport sink (input valid, scatter_red, scatter_green, scatter_blue,
                 absorb_red, absorb_green, absorb_blue, saturated_mask, output ready);
endinterface

// ----- rtl/asc_front.sv -----
`timescale 1ns / 1ps
module asc_front (
   input  logic                 clock,
   input  logic                 reset,
   asc_req_if.sink              req_ch,
   input  logic                 q_full,
   output logic                 q_push,
   output asc_pkg::entry_type   q_data
);
   logic [16:0] refl [asc_pkg::CH];
   logic [31:0] path [asc_pkg::CH];
   logic [asc_pkg::IDX_W-1:0] idx [asc_pkg::CH];
   logic [asc_pkg::IDX_PROD_W-1:0] prod [asc_pkg::CH];

   logic f1_valid_ff, f1_valid_in;
   logic f2_valid_ff, f2_valid_in;
   logic [asc_pkg::IDX_W-1:0] f1_idx_ff [asc_pkg::CH];
   logic [31:0] f1_path_ff [asc_pkg::CH];
   logic [31:0] f2_path_ff [asc_pkg::CH];
   logic [asc_pkg::ALPHA_W-1:0] f2_alpha_ff [asc_pkg::CH];
   logic [asc_pkg::SQRT_W-1:0] f2_sqrt_ff [asc_pkg::CH];
   logic adv;

   assign refl[0] = req_ch.refl_red;
   assign refl[1] = req_ch.refl_green;
   assign refl[2] = req_ch.refl_blue;
   assign path[0] = req_ch.path_red;
   assign path[1] = req_ch.path_green;
   assign path[2] = req_ch.path_blue;

   assign adv = !f2_valid_ff || !q_full;
   assign req_ch.ready = adv;
   assign q_push = f2_valid_ff && !q_full;
   assign f1_valid_in = req_ch.valid;
   assign f2_valid_in = f1_valid_ff;

   always_comb begin
      for (int c = 0; c < asc_pkg::CH; c++) begin
         prod[c] = (asc_pkg::IDX_PROD_W'(refl[c]) * asc_pkg::IDX_PROD_W'(asc_pkg::TABLE_ENTRIES)
                    + asc_pkg::IDX_PROD_W'(32768)) >> 16;
         if (prod[c] > asc_pkg::IDX_PROD_W'(asc_pkg::IDX_MAX)) begin
            idx[c] = asc_pkg::IDX_W'(asc_pkg::IDX_MAX);
         end else begin
            idx[c] = prod[c][asc_pkg::IDX_W-1:0];
         end
         q_data[c].alpha = f2_alpha_ff[c];
         q_data[c].d = asc_pkg::D_W'(f2_path_ff[c]) * asc_pkg::D_W'(f2_sqrt_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < asc_pkg::CH; c++) begin
            f1_idx_ff[c] <= idx[c];
            f1_path_ff[c] <= path[c];
            f2_path_ff[c] <= f1_path_ff[c];
            f2_alpha_ff[c] <= asc_pkg::ALPHA_ROM[f1_idx_ff[c]];
            f2_sqrt_ff[c] <= asc_pkg::SQRT_ROM[f1_idx_ff[c]];
         end
      end
   end
endmodule

// ----- rtl/asc_queue.sv -----
`timescale 1ns / 1ps
module asc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  asc_pkg::entry_type     wr_data,
   output asc_pkg::entry_type     rd_data,
   input  asc_pkg::queue_ctl_type ctl_in,
   output asc_pkg::queue_ctl_type ctl_out
);
   asc_pkg::entry_type mem_ff [asc_pkg::QUEUE_DEPTH];
   logic [asc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [asc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [asc_pkg::QPTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign ctl_out.full = (count_ff == (asc_pkg::QPTR_W+1)'(asc_pkg::QUEUE_DEPTH));
   assign ctl_out.empty = (count_ff == '0);
   assign ctl_out.push = do_push;
   assign ctl_out.pop = do_pop;
   assign do_push = ctl_in.push && !ctl_out.full;
   assign do_pop = ctl_in.pop && !ctl_out.empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (asc_pkg::QPTR_W+1)'(do_push) - (asc_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

// ----- rtl/asc_back.sv -----
`timescale 1ns / 1ps
module asc_back (
   input  logic               clock,
   input  logic               reset,
   input  asc_pkg::entry_type q_data,
   input  logic               q_empty,
   output logic               q_pop,
   asc_rsp_if.source          rsp_ch
);
   localparam int NSTG = asc_pkg::Q_W + 1;

   asc_pkg::div_type stg_ff [NSTG][asc_pkg::CH];
   asc_pkg::div_type stg_in [NSTG][asc_pkg::CH];
   logic [NSTG-1:0] vld_ff;
   logic m_valid_ff, out_valid_ff;
   logic [asc_pkg::Q_W+asc_pkg::ALPHA_W-1:0] m_prod_ff [asc_pkg::CH];
   logic [asc_pkg::Q_W-1:0] m_q_ff [asc_pkg::CH];
   logic [asc_pkg::CH-1:0] m_sat_ff;
   logic [31:0] scat_ff [asc_pkg::CH];
   logic [31:0] absb_ff [asc_pkg::CH];
   logic [asc_pkg::CH-1:0] sat_ff;
   logic [asc_pkg::Q_W+asc_pkg::ALPHA_W:0] rnd [asc_pkg::CH];
   logic [asc_pkg::Q_W-1:0] ss [asc_pkg::CH];
   logic [asc_pkg::D_W-1:0] num [asc_pkg::CH];
   logic [asc_pkg::D_W:0] rr [NSTG-1][asc_pkg::CH];
   logic adv;

   assign adv = !out_valid_ff || rsp_ch.ready;
   assign q_pop = adv && !q_empty;

   always_comb begin
      for (int c = 0; c < asc_pkg::CH; c++) begin
         // numerator 2^56 + d/2, rounds the quotient to nearest
         num[c] = (asc_pkg::D_W'(1) << 56) + (q_data[c].d >> 1);
         stg_in[0][c].d = q_data[c].d;
         stg_in[0][c].alpha = q_data[c].alpha;
         stg_in[0][c].rem = asc_pkg::D_W'(num[c][asc_pkg::D_W-1:32]);
         stg_in[0][c].nlow = num[c][31:0];
         stg_in[0][c].q = '0;
         // zero path also lands here since then d is zero
         stg_in[0][c].sat = (asc_pkg::D_W'(num[c][asc_pkg::D_W-1:32]) >= q_data[c].d);
      end
      for (int k = 0; k < NSTG - 1; k++) begin
         for (int c = 0; c < asc_pkg::CH; c++) begin
            stg_in[k+1][c] = stg_ff[k][c];
            rr[k][c] = {stg_ff[k][c].rem, stg_ff[k][c].nlow[31]};
            stg_in[k+1][c].nlow = {stg_ff[k][c].nlow[30:0], 1'b0};
            if (rr[k][c] >= {1'b0, stg_ff[k][c].d}) begin
               stg_in[k+1][c].rem = asc_pkg::D_W'(rr[k][c] - {1'b0, stg_ff[k][c].d});
               stg_in[k+1][c].q = {stg_ff[k][c].q[30:0], 1'b1};
            end else begin
               stg_in[k+1][c].rem = rr[k][c][asc_pkg::D_W-1:0];
               stg_in[k+1][c].q = {stg_ff[k][c].q[30:0], 1'b0};
            end
         end
      end
      for (int c = 0; c < asc_pkg::CH; c++) begin
         rnd[c] = (asc_pkg::Q_W+asc_pkg::ALPHA_W+1)'(m_prod_ff[c]) + 32768;
         ss[c] = rnd[c][asc_pkg::Q_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         m_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], q_pop};
         m_valid_ff <= vld_ff[NSTG-1];
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSTG; k++) begin
            for (int c = 0; c < asc_pkg::CH; c++) begin
               stg_ff[k][c] <= stg_in[k][c];
            end
         end
         for (int c = 0; c < asc_pkg::CH; c++) begin
            m_prod_ff[c] <= (asc_pkg::Q_W+asc_pkg::ALPHA_W)'(stg_ff[NSTG-1][c].alpha)
                            * (asc_pkg::Q_W+asc_pkg::ALPHA_W)'(stg_ff[NSTG-1][c].q);
            m_q_ff[c] <= stg_ff[NSTG-1][c].q;
            m_sat_ff[c] <= stg_ff[NSTG-1][c].sat;
            scat_ff[c] <= m_sat_ff[c] ? 32'hFFFF_FFFF : ss[c];
            absb_ff[c] <= m_sat_ff[c] ? 32'hFFFF_FFFF : m_q_ff[c] - ss[c];
         end
         sat_ff <= m_sat_ff;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.scatter_red = scat_ff[0];
   assign rsp_ch.scatter_green = scat_ff[1];
   assign rsp_ch.scatter_blue = scat_ff[2];
   assign rsp_ch.absorb_red = absb_ff[0];
   assign rsp_ch.absorb_green = absb_ff[1];
   assign rsp_ch.absorb_blue = absb_ff[2];
   assign rsp_ch.saturated_mask = sat_ff;
endmodule

// ----- rtl/albedo_to_scattering_coefficients.sv -----
`timescale 1ns / 1ps
// Converts per-channel diffuse reflectance and mean free path into
// scattering and absorption coefficients (Q16.16).
// Channels: req_ch carries one request with three reflectances and three
// paths; rsp_ch returns one result per request with three scatter, three
// absorb values and a saturated mask. Both use valid/ready; a transfer
// happens when both are high.
// Throughput: one request per cycle sustained while rsp_ch.ready is high.
// The front takes a request each cycle it is not held by a full queue
// (index, alpha/sqrt table read, path multiply) and hands it to a
// four-entry queue; the back is a 33-stage restoring divider (an entry
// stage, then one quotient bit per stage), then a multiply stage and
// an output register.
// Zero path or a quotient above 32 bits returns all ones for that channel
// and sets its mask bit.
// Reset (synchronous) empties the queue and all pipeline stages; nothing
// else needs clearing. When rsp_ch.ready is low the back pipeline holds,
// the queue fills, and then req_ch.ready drops.
module albedo_to_scattering_coefficients (
   input  logic      clock,
   input  logic      reset,
   asc_req_if.sink   req_ch,
   asc_rsp_if.source rsp_ch
);
   asc_pkg::entry_type push_data, pop_data;
   asc_pkg::queue_ctl_type ctl_in, ctl_out;
   logic push, pop;

   assign ctl_in.push = push;
   assign ctl_in.pop = pop;
   assign ctl_in.full = 1'b0;
   assign ctl_in.empty = 1'b0;

   asc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (ctl_out.full),
      .q_push (push),
      .q_data (push_data)
   );

   asc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_data (push_data),
      .rd_data (pop_data),
      .ctl_in  (ctl_in),
      .ctl_out (ctl_out)
   );

   asc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (pop_data),
      .q_empty (ctl_out.empty),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );
endmodule

// ----- tb/asc_tb_if.sv -----
`timescale 1ns / 1ps
// the block's interfaces are part of the rtl; this file holds the small
// request and result records the testbench passes between its tasks
package asc_tb_pkg;
   typedef struct {
      logic [16:0] refl [3];
      logic [31:0] path [3];
   } texel_type;

   typedef struct {
      logic [31:0] scatter [3];
      logic [31:0] absorb [3];
      logic [2:0]  mask;
   } coeff_type;
endpackage

// ----- tb/albedo_to_scattering_coefficients_tb.sv -----
`timescale 1ns / 1ps
module albedo_to_scattering_coefficients_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 60;

   logic clock;
   logic reset;

   asc_req_if req_ch ();
   asc_rsp_if rsp_ch ();

   albedo_to_scattering_coefficients uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   asc_tb_pkg::coeff_type expected_coeffs[$];
   int send_idle_pct;
   int stall_pct;
   bit hold_off;
   int errors;
   int n_requests;
   int n_results;
   int n_saturated;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // alpha rom entry, rounded to Q0.16
   function automatic longint unsigned alpha_of(int unsigned idx);
      longint unsigned scaled;
      if (idx >= asc_pkg::ROM_SIZE) idx = asc_pkg::ROM_SIZE - 1;
      if (idx < asc_pkg::ROM_HEAD) begin
         scaled = longint'(asc_pkg::ALPHA_HEAD[idx]);
         return (scaled * 65536 + 50000000) / 100000000;
      end
      scaled = longint'(asc_pkg::ALPHA_TAIL[idx - asc_pkg::ROM_HEAD]);
      return (scaled * 65536 + 500000) / 1000000;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned val);
      longint unsigned r;
      longint unsigned lo;
      longint unsigned hi;
      lo = 0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
         r = (lo + hi + 1) >> 1;
         if (r * r <= val) lo = r;
         else hi = r - 1;
      end
      return lo;
   endfunction

   function automatic asc_tb_pkg::coeff_type scattering_of(asc_tb_pkg::texel_type tx);
      asc_tb_pkg::coeff_type c;
      longint unsigned idx;
      longint unsigned alpha;
      longint unsigned root;
      longint unsigned dnm;
      longint unsigned total;
      longint unsigned sc;
      c.mask = '0;
      for (int ch = 0; ch < 3; ch++) begin
         idx = (longint'(tx.refl[ch]) * asc_pkg::TABLE_ENTRIES + 32768) >> 16;
         if (idx > asc_pkg::TABLE_ENTRIES - 1) idx = asc_pkg::TABLE_ENTRIES - 1;
         alpha = alpha_of(32'(idx));
         root = root_floor((3 * (65536 - alpha)) << 32);
         dnm = longint'(tx.path[ch]) * root;
         total = (dnm == 0) ? 0 : ((64'd1 << 56) + (dnm >> 1)) / dnm;
         if (dnm == 0 || total > 64'hFFFF_FFFF) begin
            c.scatter[ch] = '1;
            c.absorb[ch] = '1;
            c.mask[ch] = 1'b1;
         end else begin
            sc = (alpha * total + 32768) >> 16;
            c.scatter[ch] = sc[31:0];
            c.absorb[ch] = total[31:0] - sc[31:0];
         end
      end
      return c;
   endfunction

   // valid stays high between requests unless the sender idles
   task automatic send_texel(asc_tb_pkg::texel_type tx);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.refl_red <= tx.refl[0];
      req_ch.refl_green <= tx.refl[1];
      req_ch.refl_blue <= tx.refl[2];
      req_ch.path_red <= tx.path[0];
      req_ch.path_green <= tx.path[1];
      req_ch.path_blue <= tx.path[2];
      do @(posedge clock); while (!req_ch.ready);
      expected_coeffs.push_back(scattering_of(tx));
      n_requests++;
      @(negedge clock);
   endtask

   // reflectance with extra weight on the rounding edges and values above one
   function automatic logic [16:0] pick_refl();
      case ($urandom_range(5, 0))
         0: return 17'(65536);
         1: return 17'($urandom_range(131071, 65537));
         2: return 17'(($urandom_range(999, 0) * 65536 + 500) / 1000);
         default: return 17'($urandom_range(65535, 0));
      endcase
   endfunction

   // short paths overflow, long ones give tiny coefficients
   function automatic logic [31:0] pick_path();
      case ($urandom_range(7, 0))
         0: return 32'd0;
         1: return 32'($urandom_range(255, 1));
         2: return 32'($urandom_range(65535, 256));
         3: return $urandom();
         4: return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(32'h0100_0000, 32'h0000_1000));
      endcase
   endfunction

   task automatic test_directed();
      asc_tb_pkg::texel_type tx;
      logic [16:0] refl_edges [6];
      logic [31:0] path_edges [6];
      refl_edges = '{17'd0, 17'd33, 17'd65470, 17'd65536, 17'h1FFFF, 17'h15555};
      path_edges = '{32'd0, 32'd1, 32'd2, 32'h0001_0000, 32'hFFFF_FFFF, 32'hAAAA_5555};
      for (int i = 0; i < 6; i++) begin
         for (int ch = 0; ch < 3; ch++) begin
            tx.refl[ch] = refl_edges[(i + ch) % 6];
            tx.path[ch] = path_edges[(i + 2 * ch) % 6];
         end
         send_texel(tx);
      end
      // zero path on one channel only, and the inverted bit patterns
      for (int ch = 0; ch < 3; ch++) begin
         tx.refl = '{17'h0AAAA, 17'h15555, 17'd32768};
         tx.path = '{32'h0005_0000, 32'h0005_0000, 32'h0005_0000};
         tx.path[ch] = 32'd0;
         send_texel(tx);
      end
      tx.refl = '{17'h15555, 17'h0AAAA, 17'h1FFFF};
      tx.path = '{32'h5555_AAAA, 32'hFFFF_0000, 32'h0000_FFFF};
      send_texel(tx);
   endtask

   task automatic test_random(int count, int src_pct, int snk_pct);
      asc_tb_pkg::texel_type tx;
      send_idle_pct = src_pct;
      stall_pct = snk_pct;
      for (int i = 0; i < count; i++) begin
         for (int ch = 0; ch < 3; ch++) begin
            tx.refl[ch] = pick_refl();
            tx.path[ch] = pick_path();
         end
         send_texel(tx);
      end
   endtask

   // the receiver holds off long enough for the queue to fill and stall requests
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            for (int i = 0; i < 300; i++) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(60, 0, 0);
      join
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.refl_red = '0;
      req_ch.refl_green = '0;
      req_ch.refl_blue = '0;
      req_ch.path_red = '0;
      req_ch.path_green = '0;
      req_ch.path_blue = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      errors = 0;
      n_requests = 0;
      n_results = 0;
      n_saturated = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(250, 0, 0);
      test_random(200, 67, 0);
      test_random(200, 0, 67);
      test_random(200, 7, 7);
      test_backpressure();
      req_ch.valid <= 1'b0;

      send_idle_pct = 0;
      stall_pct = 0;
      while (expected_coeffs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d with a saturated channel",
               n_requests, n_results, n_saturated);
      $display("covered zero and huge paths, reflectance above one, idle and stall phases");
      if (errors == 0 && expected_coeffs.size() == 0) begin
         $display("albedo_to_scattering_coefficients test passed");
      end else begin
         $display("albedo_to_scattering_coefficients test failed");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
      end
   end

   always @(posedge clock) begin
      asc_tb_pkg::coeff_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_results++;
         if (expected_coeffs.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            want = expected_coeffs.pop_front();
            if (want.mask != 0) n_saturated++;
            if (rsp_ch.scatter_red !== want.scatter[0]) begin
               $error("scatter_red expected %h got %h", want.scatter[0], rsp_ch.scatter_red);
               errors++;
            end
            if (rsp_ch.scatter_green !== want.scatter[1]) begin
               $error("scatter_green expected %h got %h", want.scatter[1],
                      rsp_ch.scatter_green);
               errors++;
            end
            if (rsp_ch.scatter_blue !== want.scatter[2]) begin
               $error("scatter_blue expected %h got %h", want.scatter[2], rsp_ch.scatter_blue);
               errors++;
            end
            if (rsp_ch.absorb_red !== want.absorb[0]) begin
               $error("absorb_red expected %h got %h", want.absorb[0], rsp_ch.absorb_red);
               errors++;
            end
            if (rsp_ch.absorb_green !== want.absorb[1]) begin
               $error("absorb_green expected %h got %h", want.absorb[1], rsp_ch.absorb_green);
               errors++;
            end
            if (rsp_ch.absorb_blue !== want.absorb[2]) begin
               $error("absorb_blue expected %h got %h", want.absorb[2], rsp_ch.absorb_blue);
               errors++;
            end
            if (rsp_ch.saturated_mask !== want.mask) begin
               $error("saturated_mask expected %h got %h", want.mask, rsp_ch.saturated_mask);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("albedo_to_scattering_coefficients test failed");
            $finish;
         end
      end
   end

endmodule
